// ===== src/assert_macros.svh =====
// Assertion macros for the RTL modules; wcp_emitter is the one that uses them.
// No dependencies; compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/wcp_pkg.sv =====
// Package for the WAV chunk parser: payload structs, codes and constants.
// No dependencies.
package wcp_pkg;

  localparam int MAX_SAMPLE_BYTES_DEF = 8;
  localparam logic [15:0] TAG_CAP_RESET = 16'd64;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_DEAD    = 4'd1;
  localparam logic [3:0] PH_CHUNK   = 4'd2;
  localparam logic [3:0] PH_SKIP    = 4'd3;
  localparam logic [3:0] PH_DATA    = 4'd4;
  localparam logic [3:0] PH_LTYPE   = 4'd5;
  localparam logic [3:0] PH_SUBHDR  = 4'd6;
  localparam logic [3:0] PH_SUBBODY = 4'd7;

  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_TAG    = 2'd1;
  localparam logic [1:0] KIND_AUDIO  = 2'd2;
  localparam logic [1:0] KIND_REJECT = 2'd3;

  localparam logic [1:0] REJ_HEADER = 2'd0;
  localparam logic [1:0] REJ_BITS   = 2'd1;
  localparam logic [1:0] REJ_NODATA = 2'd2;

  localparam logic [1:0] TAG_TITLE  = 2'd0;
  localparam logic [1:0] TAG_ARTIST = 2'd1;
  localparam logic [1:0] TAG_ALBUM  = 2'd2;

  localparam logic [31:0] ID_RIFF = 32'h4646_4952;
  localparam logic [31:0] ID_WAVE = 32'h4556_4157;
  localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [31:0] ID_LIST = 32'h5453_494C;
  localparam logic [31:0] ID_INAM = 32'h4D41_4E49;
  localparam logic [31:0] ID_IART = 32'h5452_4149;
  localparam logic [31:0] ID_IPRD = 32'h4452_5049;

  localparam logic [5:0] HDR_LAST = 6'd35;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  tag_id;
    logic [7:0]  byte_value;
    logic [15:0] channels_out;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic        last;
  } out_t;

  // Result run handed from parser to emitter.
  typedef struct packed {
    logic load;
    logic burst;
    logic extra;
    out_t first;
  } run_t;

endpackage

// ===== src/wcp_parser.sv =====
// Byte-level chunk parser: header check, chunk walk, LIST tags, mono buffer.
// Depends on wcp_pkg.
module wcp_parser #(
  parameter int MAX_SAMPLE_BYTES = 8,
  parameter int BW = $clog2(MAX_SAMPLE_BYTES + 1),
  parameter int AW = (MAX_SAMPLE_BYTES > 1) ? $clog2(MAX_SAMPLE_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  wcp_pkg::in_t      in_data,
  input  logic [15:0]       tag_cap,
  output wcp_pkg::run_t     run,
  output logic [BW-1:0]     run_bb,
  output logic [7:0]        run_bytes [MAX_SAMPLE_BYTES]
);
  import wcp_pkg::*;

  logic [3:0]  phase_r, phase_nxt;
  logic [5:0]  bcnt_r, bcnt_nxt;
  logic [31:0] id_r, id_nxt, size_r, size_nxt;
  logic [31:0] chunk_rem_r, chunk_rem_nxt, list_rem_r, list_rem_nxt;
  logic [31:0] sub_rem_r, sub_rem_nxt;
  logic [15:0] tcnt_r, tcnt_nxt, chan_r, chan_nxt, bits_r, bits_nxt;
  logic [1:0]  ctag_r, ctag_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [BW-1:0] fill_r, fill_nxt;
  logic        dseen_r, dseen_nxt, lseen_r, lseen_nxt;
  logic [7:0]  sbuf_r [MAX_SAMPLE_BYTES];

  logic [7:0]  b;
  logic [16:0] bb_wide;
  logic        bits_ok;
  logic        prim, burst, rej;
  out_t        prim_res, rej_res;
  logic        is_tag;
  logic [15:0] lim;
  logic [31:0] psize;

  assign b = in_data.file_byte;
  assign bb_wide = ({1'b0, bits_r} + 17'd7) >> 3;
  assign bits_ok = (bits_r >= 16'd8) && (bb_wide <= 17'(MAX_SAMPLE_BYTES));
  assign run_bb = bb_wide[BW-1:0];

  always_comb begin
    for (int j = 0; j < MAX_SAMPLE_BYTES; j++) begin
      run_bytes[j] = (fill_r == BW'(j)) ? b : sbuf_r[j];
    end
  end

  always_comb begin
    phase_nxt = phase_r; bcnt_nxt = bcnt_r; id_nxt = id_r; size_nxt = size_r;
    chunk_rem_nxt = chunk_rem_r; list_rem_nxt = list_rem_r; sub_rem_nxt = sub_rem_r;
    tcnt_nxt = tcnt_r; ctag_nxt = ctag_r; chan_nxt = chan_r; rate_nxt = rate_r;
    bits_nxt = bits_r; fill_nxt = fill_r; dseen_nxt = dseen_r; lseen_nxt = lseen_r;
    prim = 1'b0; burst = 1'b0; prim_res = '0; rej = 1'b0; rej_res = '0;
    is_tag = 1'b0; lim = tag_cap - 16'd1; psize = '0;
    case (phase_r)
      PH_HEADER: begin
        id_nxt = {b, id_r[31:8]};
        case (bcnt_r)
          6'd22: chan_nxt[7:0] = b;
          6'd23: chan_nxt[15:8] = b;
          6'd24: rate_nxt[7:0] = b;
          6'd25: rate_nxt[15:8] = b;
          6'd26: rate_nxt[23:16] = b;
          6'd27: rate_nxt[31:24] = b;
          6'd34: bits_nxt[7:0] = b;
          6'd35: bits_nxt[15:8] = b;
          default: ;
        endcase
        if ((bcnt_r == 6'd3 && id_nxt != ID_RIFF) || (bcnt_r == 6'd11 && id_nxt != ID_WAVE)
            || (bcnt_r == 6'd15 && id_nxt != ID_FMT)) begin
          prim = 1'b1;
          prim_res.kind = KIND_REJECT;
          prim_res.tag_id = REJ_HEADER;
          phase_nxt = PH_DEAD;
        end else if (bcnt_r >= HDR_LAST) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
        end else begin
          bcnt_nxt = bcnt_r + 6'd1;
        end
      end
      PH_CHUNK: begin
        if (bcnt_r < 6'd4) id_nxt = {b, id_r[31:8]};
        else size_nxt = {b, size_r[31:8]};
        if (bcnt_r >= 6'd7) begin
          bcnt_nxt = '0;
          if (id_r == ID_DATA && !dseen_r) begin
            dseen_nxt = 1'b1;
            chunk_rem_nxt = size_nxt;
            fill_nxt = '0;
            prim = 1'b1;
            if (bits_ok) begin
              prim_res.kind = KIND_FORMAT;
              prim_res.channels_out = (chan_r == 16'd1) ? 16'd2 : chan_r;
              prim_res.sample_rate = rate_r;
              prim_res.bits_per_sample = bits_r;
              prim_res.data_size = size_nxt;
              phase_nxt = (size_nxt != 0) ? PH_DATA : PH_CHUNK;
            end else begin
              prim_res.kind = KIND_REJECT;
              prim_res.tag_id = REJ_BITS;
              phase_nxt = (size_nxt != 0) ? PH_SKIP : PH_CHUNK;
            end
          end else if (id_r == ID_LIST && (!dseen_r || !lseen_r)) begin
            lseen_nxt = 1'b1;
            list_rem_nxt = size_nxt;
            phase_nxt = (size_nxt != 0) ? PH_LTYPE : PH_CHUNK;
          end else begin
            chunk_rem_nxt = size_nxt;
            phase_nxt = (size_nxt != 0) ? PH_SKIP : PH_CHUNK;
          end
        end else begin
          bcnt_nxt = bcnt_r + 6'd1;
        end
      end
      PH_SKIP: begin
        chunk_rem_nxt = chunk_rem_r - 32'd1;
        if (chunk_rem_nxt == 0) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
        end
      end
      PH_DATA: begin
        if (chan_r == 16'd1) begin
          fill_nxt = fill_r + BW'(1);
          if (17'(fill_nxt) >= bb_wide) begin
            burst = 1'b1;
            fill_nxt = '0;
          end
        end else begin
          prim = 1'b1;
          prim_res.kind = KIND_AUDIO;
          prim_res.byte_value = b;
        end
        chunk_rem_nxt = chunk_rem_r - 32'd1;
        if (chunk_rem_nxt == 0) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
          fill_nxt = '0;
        end
      end
      PH_LTYPE: begin
        list_rem_nxt = list_rem_r - 32'd1;
        bcnt_nxt = bcnt_r + 6'd1;
        if (list_rem_nxt == 0) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
        end else if (bcnt_nxt >= 6'd4) begin
          phase_nxt = PH_SUBHDR;
          bcnt_nxt = '0;
        end
      end
      PH_SUBHDR: begin
        if (bcnt_r < 6'd4) id_nxt = {b, id_r[31:8]};
        else size_nxt = {b, size_r[31:8]};
        list_rem_nxt = list_rem_r - 32'd1;
        if (bcnt_r >= 6'd7) begin
          bcnt_nxt = '0;
          is_tag = 1'b1;
          if (id_r == ID_INAM) ctag_nxt = TAG_TITLE;
          else if (id_r == ID_IART) ctag_nxt = TAG_ARTIST;
          else if (id_r == ID_IPRD) ctag_nxt = TAG_ALBUM;
          else begin
            is_tag = 1'b0;
            ctag_nxt = TAG_TITLE;
          end
          tcnt_nxt = '0;
          if (is_tag && tag_cap != 16'd0) begin
            tcnt_nxt = (size_nxt > 32'(lim)) ? lim : size_nxt[15:0];
          end
          psize = size_nxt;
          if (size_nxt[0] && size_nxt != 32'hFFFF_FFFF) psize = size_nxt + 32'd1;
          sub_rem_nxt = psize;
          if (list_rem_nxt == 0) phase_nxt = PH_CHUNK;
          else if (psize == 0) phase_nxt = PH_SUBHDR;
          else phase_nxt = PH_SUBBODY;
        end else if (list_rem_nxt == 0) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
        end else begin
          bcnt_nxt = bcnt_r + 6'd1;
        end
      end
      PH_SUBBODY: begin
        if (tcnt_r != 16'd0) begin
          prim = 1'b1;
          prim_res.kind = KIND_TAG;
          prim_res.tag_id = ctag_r;
          prim_res.byte_value = b;
          tcnt_nxt = tcnt_r - 16'd1;
        end
        sub_rem_nxt = sub_rem_r - 32'd1;
        list_rem_nxt = list_rem_r - 32'd1;
        if (list_rem_nxt == 0) begin
          phase_nxt = PH_CHUNK;
          bcnt_nxt = '0;
        end else if (sub_rem_nxt == 0) begin
          phase_nxt = PH_SUBHDR;
          bcnt_nxt = '0;
        end
      end
      default: ;
    endcase

    if (in_data.end_of_file) begin
      rej_res.kind = KIND_REJECT;
      if (phase_nxt == PH_HEADER) begin
        rej = 1'b1;
        rej_res.tag_id = REJ_HEADER;
      end else if (phase_nxt != PH_DEAD && phase_nxt <= PH_SUBBODY && !dseen_nxt) begin
        rej = 1'b1;
        rej_res.tag_id = REJ_NODATA;
      end
      phase_nxt = PH_HEADER; bcnt_nxt = '0; id_nxt = '0; size_nxt = '0;
      chunk_rem_nxt = '0; list_rem_nxt = '0; sub_rem_nxt = '0; tcnt_nxt = '0;
      ctag_nxt = '0; chan_nxt = '0; rate_nxt = '0; bits_nxt = '0; fill_nxt = '0;
      dseen_nxt = 1'b0; lseen_nxt = 1'b0;
    end

    run.load  = prim || burst || rej;
    run.burst = burst;
    run.extra = prim && rej;
    run.first = prim ? prim_res : rej_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER; bcnt_r <= '0; id_r <= '0; size_r <= '0;
      chunk_rem_r <= '0; list_rem_r <= '0; sub_rem_r <= '0; tcnt_r <= '0;
      ctag_r <= '0; chan_r <= '0; rate_r <= '0; bits_r <= '0; fill_r <= '0;
      dseen_r <= 1'b0; lseen_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; bcnt_r <= bcnt_nxt; id_r <= id_nxt; size_r <= size_nxt;
      chunk_rem_r <= chunk_rem_nxt; list_rem_r <= list_rem_nxt;
      sub_rem_r <= sub_rem_nxt; tcnt_r <= tcnt_nxt; ctag_r <= ctag_nxt;
      chan_r <= chan_nxt; rate_r <= rate_nxt; bits_r <= bits_nxt;
      fill_r <= fill_nxt; dseen_r <= dseen_nxt; lseen_r <= lseen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && phase_r == PH_DATA && chan_r == 16'd1) begin
      sbuf_r[fill_r[AW-1:0]] <= b;
    end
  end

endmodule

// ===== src/wcp_emitter.sv =====
// Result sequencer: holds one run and delivers it one transaction per cycle while out_ready is high.
// Depends on wcp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wcp_emitter #(
  parameter int MAX_SAMPLE_BYTES = 8,
  parameter int BW = $clog2(MAX_SAMPLE_BYTES + 1),
  parameter int IW = $clog2(2 * MAX_SAMPLE_BYTES),
  parameter int AW = (MAX_SAMPLE_BYTES > 1) ? $clog2(MAX_SAMPLE_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wcp_pkg::run_t     run,
  input  logic [BW-1:0]     run_bb,
  input  logic [7:0]        run_bytes [MAX_SAMPLE_BYTES],
  output logic              take_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wcp_pkg::out_t     out_data
);
  import wcp_pkg::*;

  logic          busy_r, burst_r, extra_r, first_r;
  out_t          res_r;
  logic [BW-1:0] bb_r;
  logic [IW-1:0] idx_r;
  logic [7:0]    buf_r [MAX_SAMPLE_BYTES];
  logic [IW:0]   idx_x, bb_x, k;
  logic          is_last;

  assign idx_x = {1'b0, idx_r};
  assign bb_x  = (IW + 1)'(bb_r);
  assign k     = (idx_x < bb_x) ? idx_x : idx_x - bb_x;
  assign is_last = burst_r ? (idx_x == (bb_x << 1) - (IW + 1)'(1))
                           : (first_r ? !extra_r : 1'b1);
  assign out_valid  = busy_r;
  assign take_ready = !busy_r || (out_ready && is_last);

  always_comb begin
    out_data = '0;
    if (burst_r) begin
      out_data.kind = KIND_AUDIO;
      out_data.byte_value = buf_r[k[AW-1:0]];
    end else if (first_r) begin
      out_data = res_r;
    end else begin
      out_data.kind = KIND_REJECT;
      out_data.tag_id = REJ_NODATA;
    end
    out_data.last = is_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; burst_r <= 1'b0; extra_r <= 1'b0; first_r <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      busy_r <= 1'b1; burst_r <= run.burst; extra_r <= run.extra;
      first_r <= !run.burst; idx_r <= '0;
    end else if (busy_r && out_ready) begin
      if (is_last) busy_r <= 1'b0;
      else if (burst_r) idx_r <= idx_r + IW'(1);
      else first_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= run.first;
      bb_r  <= run_bb;
      for (int j = 0; j < MAX_SAMPLE_BYTES; j++) buf_r[j] <= run_bytes[j];
    end
  end

  `ASSERT_ALWAYS(a_load_free, clk, rst_n, !load || take_ready)
  `ASSERT_ALWAYS(a_burst_bb, clk, rst_n, !(busy_r && burst_r) || (bb_r != '0))
  `ASSERT_ALWAYS(a_idx_range, clk, rst_n, !(busy_r && burst_r) || (idx_x < (bb_x << 1)))
  `ASSERT_NEXT(a_hold, clk, rst_n, busy_r && !out_ready, busy_r && $stable(idx_r))
endmodule

// ===== src/wav_chunk_parser_mono_to_stereo.sv =====
// Top level of the WAV chunk parser with mono-to-stereo expansion.
// Depends on wcp_pkg, wcp_parser and wcp_emitter.
//
//  channel | ports                         | carries
//  in      | in_valid/in_ready/in_data     | one file byte + end flag
//  out     | out_valid/out_ready/out_data  | one result, last marks end of run
//  cfg     | cfg_valid/cfg_ready/cfg_data  | tag_capacity
//
// A byte is parsed as accepted; results leave one per cycle while out_ready is high.
// A byte with results holds the input until its run is delivered; one with none does not.
// The last byte of a mono sample releases the whole sample twice, as one run.
// The next byte is taken in the cycle the final result of a run is taken.
// Synchronous active-low reset; no clearing pass. cfg_ready is always high.
module wav_chunk_parser_mono_to_stereo #(
  parameter int MAX_SAMPLE_BYTES = wcp_pkg::MAX_SAMPLE_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  wcp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output wcp_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [15:0]   cfg_data
);
  import wcp_pkg::*;

  localparam int BW = $clog2(MAX_SAMPLE_BYTES + 1);

  logic [15:0]   tag_cap_r;
  logic          fire;
  run_t          run;
  logic [BW-1:0] run_bb;
  logic [7:0]    run_bytes [MAX_SAMPLE_BYTES];
  logic          take_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = take_ready;
  assign fire      = in_valid && take_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) tag_cap_r <= TAG_CAP_RESET;
    else if (cfg_valid) tag_cap_r <= cfg_data;
  end

  wcp_parser #(.MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)) u_parser (
    .clk(clk), .rst_n(rst_n), .fire(fire), .in_data(in_data), .tag_cap(tag_cap_r),
    .run(run), .run_bb(run_bb), .run_bytes(run_bytes)
  );

  wcp_emitter #(.MAX_SAMPLE_BYTES(MAX_SAMPLE_BYTES)) u_emitter (
    .clk(clk), .rst_n(rst_n), .load(fire && run.load), .run(run), .run_bb(run_bb),
    .run_bytes(run_bytes), .take_ready(take_ready), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
  );

endmodule

// ===== tb/wcp_checker.sv =====
// Checker for the WAV chunk parser: watches the input, result and config channels,
// predicts each result from the accepted bytes and compares. Depends on wcp_pkg.
`timescale 1ns / 100ps
module wcp_checker
  import wcp_pkg::*;
#(
  parameter int MAX_SAMPLE_BYTES = MAX_SAMPLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  out_t        wav_results_q[$];
  logic [15:0] tag_cap;
  logic [3:0]  ph;
  int unsigned hdr_cnt;
  logic [31:0] id_sh, size_sh, chunk_left, list_left, sub_left;
  logic [15:0] tag_left;
  logic [1:0]  cur_tag;
  logic [15:0] chans, bits;
  logic [31:0] rate;
  logic [7:0]  samp[8];
  int unsigned fill;
  bit          data_seen, list_seen;

  initial begin
    errors = 0;
    pending = 0;
  end

  function automatic void clear_parse();
    ph = PH_HEADER;
    hdr_cnt = 0;
    id_sh = '0;
    size_sh = '0;
    chunk_left = '0;
    list_left = '0;
    sub_left = '0;
    tag_left = '0;
    cur_tag = '0;
    chans = '0;
    rate = '0;
    bits = '0;
    fill = 0;
    data_seen = 0;
    list_seen = 0;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [1:0] t, logic [7:0] v,
                                     logic [15:0] c, logic [31:0] r, logic [15:0] b,
                                     logic [31:0] s);
    out_t o;
    o = '0;
    o.kind = k;
    o.tag_id = t;
    o.byte_value = v;
    o.channels_out = c;
    o.sample_rate = r;
    o.bits_per_sample = b;
    o.data_size = s;
    wav_results_q.push_back(o);
  endfunction

  function automatic int unsigned sample_bytes();
    return (int'(bits) + 7) / 8;
  endfunction

  function automatic void shift_hdr(logic [7:0] b);
    if (hdr_cnt < 4) id_sh = {b, id_sh[31:8]};
    else size_sh = {b, size_sh[31:8]};
  endfunction

  function automatic void open_chunk();
    hdr_cnt = 0;
    if (id_sh == ID_DATA && !data_seen) begin
      data_seen = 1;
      chunk_left = size_sh;
      fill = 0;
      if (bits >= 8 && sample_bytes() <= MAX_SAMPLE_BYTES) begin
        add_result(KIND_FORMAT, '0, '0, (chans == 16'd1) ? 16'd2 : chans, rate, bits,
                   size_sh);
        ph = (size_sh != 0) ? PH_DATA : PH_CHUNK;
      end else begin
        add_result(KIND_REJECT, REJ_BITS, '0, '0, '0, '0, '0);
        ph = (size_sh != 0) ? PH_SKIP : PH_CHUNK;
      end
    end else if (id_sh == ID_LIST && (!data_seen || !list_seen)) begin
      list_seen = 1;
      list_left = size_sh;
      ph = (size_sh != 0) ? PH_LTYPE : PH_CHUNK;
    end else begin
      chunk_left = size_sh;
      ph = (size_sh != 0) ? PH_SKIP : PH_CHUNK;
    end
  endfunction

  function automatic void open_subchunk();
    logic [31:0] sz;
    logic [15:0] lim;
    bit is_tag;
    sz = size_sh;
    lim = tag_cap - 16'd1;
    is_tag = 1;
    if (id_sh == ID_INAM) cur_tag = TAG_TITLE;
    else if (id_sh == ID_IART) cur_tag = TAG_ARTIST;
    else if (id_sh == ID_IPRD) cur_tag = TAG_ALBUM;
    else begin
      is_tag = 0;
      cur_tag = TAG_TITLE;
    end
    tag_left = '0;
    if (is_tag && tag_cap != 0) tag_left = (sz > 32'(lim)) ? lim : sz[15:0];
    if (sz[0] && sz != 32'hFFFF_FFFF) sz = sz + 1;
    sub_left = sz;
  endfunction

  function automatic void parse_byte(logic [7:0] b, logic eof);
    int n0;
    int unsigned i, nb;
    n0 = wav_results_q.size();
    case (ph)
      PH_HEADER: begin
        i = hdr_cnt;
        id_sh = {b, id_sh[31:8]};
        if (i == 22) chans[7:0] = b;
        if (i == 23) chans[15:8] = b;
        if (i >= 24 && i <= 27) rate[8*(i-24) +: 8] = b;
        if (i == 34) bits[7:0] = b;
        if (i == 35) bits[15:8] = b;
        if ((i == 3 && id_sh != ID_RIFF) || (i == 11 && id_sh != ID_WAVE) ||
            (i == 15 && id_sh != ID_FMT)) begin
          add_result(KIND_REJECT, REJ_HEADER, '0, '0, '0, '0, '0);
          ph = PH_DEAD;
        end else if (i >= 35) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
        end else begin
          hdr_cnt = i + 1;
        end
      end
      PH_CHUNK: begin
        shift_hdr(b);
        if (hdr_cnt >= 7) open_chunk();
        else hdr_cnt++;
      end
      PH_SKIP: begin
        chunk_left--;
        if (chunk_left == 0) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
        end
      end
      PH_DATA: begin
        if (chans == 16'd1) begin
          nb = sample_bytes();
          samp[fill % 8] = b;
          fill++;
          if (fill >= nb) begin
            repeat (2)
              for (int k = 0; k < nb; k++)
                add_result(KIND_AUDIO, '0, samp[k % 8], '0, '0, '0, '0);
            fill = 0;
          end
        end else begin
          add_result(KIND_AUDIO, '0, b, '0, '0, '0, '0);
        end
        chunk_left--;
        if (chunk_left == 0) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
          fill = 0;
        end
      end
      PH_LTYPE: begin
        list_left--;
        hdr_cnt++;
        if (list_left == 0) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
        end else if (hdr_cnt >= 4) begin
          ph = PH_SUBHDR;
          hdr_cnt = 0;
        end
      end
      PH_SUBHDR: begin
        shift_hdr(b);
        list_left--;
        if (hdr_cnt >= 7) begin
          hdr_cnt = 0;
          open_subchunk();
          if (list_left == 0) ph = PH_CHUNK;
          else if (sub_left == 0) ph = PH_SUBHDR;
          else ph = PH_SUBBODY;
        end else if (list_left == 0) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
        end else begin
          hdr_cnt++;
        end
      end
      PH_SUBBODY: begin
        if (tag_left > 0) begin
          add_result(KIND_TAG, cur_tag, b, '0, '0, '0, '0);
          tag_left--;
        end
        sub_left--;
        list_left--;
        if (list_left == 0) begin
          ph = PH_CHUNK;
          hdr_cnt = 0;
        end else if (sub_left == 0) begin
          ph = PH_SUBHDR;
          hdr_cnt = 0;
        end
      end
      default: ;
    endcase
    if (eof) begin
      if (ph == PH_HEADER)
        add_result(KIND_REJECT, REJ_HEADER, '0, '0, '0, '0, '0);
      else if (ph != PH_DEAD && ph <= PH_SUBBODY && !data_seen)
        add_result(KIND_REJECT, REJ_NODATA, '0, '0, '0, '0, '0);
      clear_parse();
    end
    if (wav_results_q.size() > n0) wav_results_q[wav_results_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    out_t e;
    if (!rst_n) begin
      clear_parse();
      tag_cap = TAG_CAP_RESET;
      wav_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) tag_cap = cfg_data;
      if (out_valid && out_ready) begin
        if (wav_results_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $realtime, out_data);
        end else begin
          e = wav_results_q.pop_front();
          if (out_data.kind !== e.kind || out_data.tag_id !== e.tag_id ||
              out_data.byte_value !== e.byte_value ||
              out_data.channels_out !== e.channels_out ||
              out_data.sample_rate !== e.sample_rate ||
              out_data.bits_per_sample !== e.bits_per_sample ||
              out_data.data_size !== e.data_size || out_data.last !== e.last) begin
            errors++;
            $display("%0t: mismatch, expected %p, actual %p", $realtime, e, out_data);
          end
        end
      end
      if (in_valid && in_ready) parse_byte(in_data.file_byte, in_data.end_of_file);
    end
    pending = wav_results_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the WAV chunk parser testbench: clock, reset, WAV file stimulus, config writes
// and verdict. Depends on wcp_pkg, wcp_checker and the parser RTL.
`timescale 1ns / 100ps
module testbench;
  import wcp_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          errors;
  int          pending;
  int          cycles;
  int          bytes_sent;
  bit          hold_req;
  bit          hold_done;
  bit          fast_send;
  logic [7:0]  file_q[$];

  wav_chunk_parser_mono_to_stereo uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  wcp_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    hold_done = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, stall-free stretches, one long hold-off on request
  initial begin
    int r;
    int free_left;
    out_ready = 1'b0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end else begin
        r = $urandom_range(999);
        if (free_left > 0) begin
          free_left--;
          out_ready <= 1'b1;
        end else if (r < 5) begin
          free_left = $urandom_range(50, 200);
          out_ready <= 1'b1;
        end else if (r < 10) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(negedge clk);
        end else begin
          out_ready <= (r < 700);
        end
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eof);
    int gap;
    gap = 0;
    if (!fast_send && $urandom_range(9) >= 6)
      gap = ($urandom_range(19) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{file_byte: b, end_of_file: eof};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    in_valid <= 1'b0;
    file_q.delete();
    @(negedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_tag_cap(logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic put32(logic [31:0] v);
    for (int k = 0; k < 4; k++) file_q.push_back(v[8*k +: 8]);
  endtask

  task automatic put16(logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endtask

  task automatic put_rand(int n);
    repeat (n) file_q.push_back(8'($urandom));
  endtask

  task automatic put_header(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits);
    put32(ID_RIFF);
    put32($urandom);
    put32(ID_WAVE);
    put32(ID_FMT);
    put32(32'd16);
    put16(16'd1);
    put16(ch);
    put32(rate);
    put32($urandom);
    put16(16'($urandom));
    put16(bits);
  endtask

  task automatic put_chunk(logic [31:0] id, logic [31:0] size, int body);
    put32(id);
    put32(size);
    put_rand(body);
  endtask

  task automatic put_list(int nsub);
    logic [31:0] ids[4];
    logic [31:0] sz[4];
    int total;
    ids = '{ID_INAM, ID_IART, ID_IPRD, 32'h5446_5349};
    total = 4;
    for (int k = 0; k < nsub; k++) begin
      sz[k] = $urandom_range(0, 9);
      total += 8 + sz[k] + sz[k][0];
    end
    if ($urandom_range(4) == 0) total -= $urandom_range(0, 6);
    put32(ID_LIST);
    put32(total);
    put32(32'h4F46_4E49);
    for (int k = 0; k < nsub; k++)
      put_chunk(ids[$urandom_range(3)], sz[k], sz[k] + sz[k][0]);
  endtask

  task automatic random_file();
    logic [15:0] ch, bits;
    int r, nchunks, cut;
    r = $urandom_range(9);
    ch = (r < 4) ? 16'd1 : (r < 8) ? 16'd2 : 16'($urandom);
    r = $urandom_range(11);
    case (r)
      0, 1, 2: bits = 16'd8;
      3, 4: bits = 16'd16;
      5: bits = 16'd24;
      6: bits = 16'd32;
      7: bits = 16'd64;
      8: bits = 16'($urandom_range(1, 7));
      9: bits = 16'($urandom_range(57, 72));
      default: bits = 16'($urandom);
    endcase
    put_header(ch, $urandom, bits);
    if ($urandom_range(9) == 0) file_q[$urandom_range(15)] = 8'($urandom);
    nchunks = $urandom_range(1, 4);
    for (int k = 0; k < nchunks; k++) begin
      r = $urandom_range(9);
      if (r < 4) put_chunk(ID_DATA, $urandom_range(0, 16), 0);
      else if (r < 7) put_list($urandom_range(1, 4));
      else put_chunk(32'h6B6E_756A, $urandom_range(0, 5), 0);
      if (r < 4) put_rand(file_q[file_q.size()-4]);
    end
    if ($urandom_range(4) == 0) put_rand($urandom_range(1, 6));
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end
  endtask

  initial begin
    int base;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_req = 0;
    fast_send = 0;
    bytes_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // stereo file with all tag kinds, odd sizes padded, unknown subchunk
    put_header(16'd2, 32'd44100, 16'd16);
    put32(ID_LIST);
    put32(32'd4 + 14 + 12 + 12 + 10);
    put32(32'h4F46_4E49);
    put_chunk(ID_INAM, 32'd5, 6);
    put_chunk(ID_IART, 32'd4, 4);
    put_chunk(ID_IPRD, 32'd3, 4);
    put_chunk(32'h5446_5349, 32'd2, 2);
    put_chunk(ID_DATA, 32'd6, 6);
    send_file();
    // header tag mismatches, each file ending on the bad tag, and a short file
    put_header(16'd2, 32'd8000, 16'd8);
    file_q[0] = 8'h00;
    while (file_q.size() > 4) void'(file_q.pop_back());
    send_file();
    put_header(16'd2, 32'd8000, 16'd8);
    file_q[11] = 8'hFF;
    while (file_q.size() > 12) void'(file_q.pop_back());
    send_file();
    put_header(16'd2, 32'd8000, 16'd8);
    file_q[15] = 8'h00;
    while (file_q.size() > 16) void'(file_q.pop_back());
    send_file();
    put_header(16'd1, 32'hFFFF_FFFF, 16'd16);
    while (file_q.size() > 20) void'(file_q.pop_back());
    send_file();
    write_tag_cap(16'd0);
    // mono 64 bit, subchunk of maximal odd size cut at the list end
    put_header(16'd1, 32'd22050, 16'd64);
    put32(ID_LIST);
    put32(32'd4 + 12);
    put32(32'h4F46_4E49);
    put_chunk(ID_INAM, 32'hFFFF_FFFF, 4);
    put_chunk(ID_DATA, 32'd16, 16);
    send_file();
    write_tag_cap(16'($urandom_range(2, 12)));
    // long result hold-off while a mono file keeps the input offering bytes
    hold_req = 1;
    fast_send = 1;
    put_header(16'd1, 32'd8000, 16'd8);
    put_chunk(ID_DATA, 32'd16, 16);
    send_file();

    base = bytes_sent;
    while (bytes_sent < base + 40) begin
      fast_send = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) put_rand($urandom_range(1, 40));
      else random_file();
      send_file();
    end

    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== wav_chunk_parser_mono_to_stereo.f =====
+incdir+src
src/wcp_pkg.sv
src/wcp_parser.sv
src/wcp_emitter.sv
src/wav_chunk_parser_mono_to_stereo.sv
tb/wcp_checker.sv
tb/testbench.sv
